// File: rtl/core/tsp_pkg.sv
// Shared types, codes and reset constants of the trapezoid speed profile drive.
// No dependencies; every other file refers to it by scoped names.
package tsp_pkg;

  // default width to which the signed progress is saturated
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SPEED    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_STEP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECEL_STEP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_INTERVAL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_ZONE_LIMIT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_HYST   = 3'd6;

  // register reset values
  localparam logic [6:0]  MIN_SPEED_RST      = 7'd30;
  localparam logic [6:0]  MAX_SPEED_RST      = 7'd70;
  localparam logic [6:0]  ACCEL_STEP_RST     = 7'd1;
  localparam logic [6:0]  DECEL_STEP_RST     = 7'd1;
  localparam logic [15:0] RAMP_INTERVAL_RST  = 16'd50;
  localparam logic [15:0] DEAD_ZONE_LIMIT_RST = 16'd30000;
  localparam logic [7:0]  PULSE_HYST_RST     = 8'd0;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // move kinds; the fourth code runs as forward
  localparam logic [1:0] MOVE_FWD     = 2'd0;
  localparam logic [1:0] MOVE_CW      = 2'd1;
  localparam logic [1:0] MOVE_CCW     = 2'd2;
  localparam logic [1:0] MOVE_FWD_ALT = 2'd3;

  // ramp phases
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_HOLD   = 2'd1;
  localparam logic [1:0] PH_MIRROR = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  typedef struct packed {
    logic [6:0]  min_speed;
    logic [6:0]  max_speed;
    logic [6:0]  accel_step;
    logic [6:0]  decel_step;
    logic [15:0] ramp_interval_ticks;
    logic [15:0] dead_zone_limit_ticks;
    logic [7:0]  pulse_hysteresis;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         move_type;
    logic [14:0]        need_pulses;
    logic signed [15:0] left_pulses;
    logic signed [15:0] right_pulses;
  } item_t;

  typedef struct packed {
    logic [7:0]         cur_speed;
    logic signed [17:0] regulator;
    logic signed [7:0]  integral_term;
    logic [1:0]         phase;
    logic [15:0]        ramp_timer;
    logic [15:0]        dead_zone_count;
    logic [1:0]         cur_move_type;
    logic [14:0]        target_pulses;
    logic               finished;
  } state_t;

  typedef struct packed {
    logic signed [7:0] left_power;
    logic signed [7:0] right_power;
    logic              move_done;
    logic [1:0]        ramp_phase;
  } result_t;

endpackage

// File: rtl/core/trapezoid_speed_profile_pi_drive.sv
// Trapezoidal speed profile with PI steering for a differential drive.
// A request passes the input register, then one combinational update into the result register;
// a result register that holds an untaken result (out_valid without out_ready) stalls it there.
// One request per cycle while the result register is not held; the move state is written with the result.
// Reset (synchronous, rst high) restores the register defaults, marks the move
// finished and empties both pipeline registers.
module trapezoid_speed_profile_pi_drive #(
  parameter int COUNT_WIDTH = tsp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [1:0]                      move_type,
  input  logic [14:0]                     need_pulses,
  input  logic signed [15:0]              left_pulses,
  input  logic signed [15:0]              right_pulses,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [7:0]               left_power,
  output logic signed [7:0]               right_power,
  output logic                            move_done,
  output logic [1:0]                      ramp_phase
);

  tsp_pkg::cfg_t    cfg;
  tsp_pkg::item_t   s1_item;
  logic             s1_valid;
  tsp_pkg::state_t  state;
  tsp_pkg::state_t  state_next;
  tsp_pkg::result_t step_res;
  tsp_pkg::result_t out_res;
  logic             advance;

  tsp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline flow: the input register moves on when the result register frees up
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.req_type     <= req_type;
      s1_item.move_type    <= move_type;
      s1_item.need_pulses  <= need_pulses;
      s1_item.left_pulses  <= left_pulses;
      s1_item.right_pulses <= right_pulses;
    end
  end

  tsp_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg        (cfg),
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .result     (step_res)
  );

  // move state, updated once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.cur_speed       <= 8'd0;
      state.regulator       <= 18'sd0;
      state.integral_term   <= 8'sd0;
      state.phase           <= tsp_pkg::PH_ACCEL;
      state.ramp_timer      <= 16'd0;
      state.dead_zone_count <= 16'd0;
      state.cur_move_type   <= tsp_pkg::MOVE_FWD;
      state.target_pulses   <= 15'd0;
      state.finished        <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign left_power  = out_res.left_power;
  assign right_power = out_res.right_power;
  assign move_done   = out_res.move_done;
  assign ramp_phase  = out_res.ramp_phase;

  // an empty result register never holds back the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // a finished move answers every tick with done and zero power
  a_done_zero_power: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> left_power == 8'sd0 && right_power == 8'sd0)
    else $error("power driven on a finished move");

  // a tick that meets a finished move reports done
  a_tick_after_finish: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.req_type == tsp_pkg::REQ_TICK && state.finished
    |=> out_valid && move_done)
    else $error("tick on a finished move not reported as done");

  // a start request restarts the ramp and clears done
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.req_type == tsp_pkg::REQ_START
    |=> out_valid && !move_done && ramp_phase == tsp_pkg::PH_ACCEL && !state.finished)
    else $error("start request gave a wrong result");

endmodule

// File: rtl/core/tsp_cfg.sv
// Configuration register file of the speed profile drive.
// Depends on tsp_pkg for the register indexes, reset values and cfg_t.
module tsp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tsp_pkg::cfg_t                  cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_speed             <= tsp_pkg::MIN_SPEED_RST;
      cfg.max_speed             <= tsp_pkg::MAX_SPEED_RST;
      cfg.accel_step            <= tsp_pkg::ACCEL_STEP_RST;
      cfg.decel_step            <= tsp_pkg::DECEL_STEP_RST;
      cfg.ramp_interval_ticks   <= tsp_pkg::RAMP_INTERVAL_RST;
      cfg.dead_zone_limit_ticks <= tsp_pkg::DEAD_ZONE_LIMIT_RST;
      cfg.pulse_hysteresis      <= tsp_pkg::PULSE_HYST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsp_pkg::CFG_MIN_SPEED:       cfg.min_speed             <= cfg_data[6:0];
        tsp_pkg::CFG_MAX_SPEED:       cfg.max_speed             <= cfg_data[6:0];
        tsp_pkg::CFG_ACCEL_STEP:      cfg.accel_step            <= cfg_data[6:0];
        tsp_pkg::CFG_DECEL_STEP:      cfg.decel_step            <= cfg_data[6:0];
        tsp_pkg::CFG_RAMP_INTERVAL:   cfg.ramp_interval_ticks   <= cfg_data[15:0];
        tsp_pkg::CFG_DEAD_ZONE_LIMIT: cfg.dead_zone_limit_ticks <= cfg_data[15:0];
        tsp_pkg::CFG_PULSE_HYST:      cfg.pulse_hysteresis      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tsp_step.sv
// Single-pass update of the move state for one request, with its result.
// Depends on tsp_pkg for cfg_t, item_t, state_t, result_t and the codes.
module tsp_step #(
  parameter int COUNT_WIDTH = tsp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  tsp_pkg::cfg_t    cfg,
  input  tsp_pkg::item_t   item,
  input  tsp_pkg::state_t  state,
  output tsp_pkg::state_t  state_next,
  output tsp_pkg::result_t result
);

  // progress compare width: room for the halved sum and the saturation bound
  localparam int PW = ((COUNT_WIDTH > 17) ? COUNT_WIDTH : 17) + 1;
  localparam logic signed [PW-1:0] PMAX = PW'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] PMIN = ~PMAX;

  logic [1:0]          mt;
  logic signed [16:0]  lc;
  logic signed [16:0]  rc;
  logic signed [16:0]  pair;
  logic signed [16:0]  half_pair;
  logic signed [PW-1:0] prog_wide;
  logic signed [PW-1:0] prog;
  logic signed [PW-1:0] target_ext;
  logic signed [PW-1:0] half_ext;
  logic                reached;
  logic                below_half;

  logic [15:0] timer_dec;
  logic [15:0] dz_pre;

  logic [7:0]  sp;
  logic [1:0]  ph;
  logic [15:0] tm;
  logic [15:0] dz;
  logic [8:0]  decel_floor;

  logic [7:0]          drive_speed;
  logic signed [19:0]  drive_l;
  logic signed [19:0]  drive_r;
  logic [6:0]          clamp_l;
  logic [6:0]          clamp_r;
  logic signed [7:0]   power_l;
  logic signed [7:0]   power_r;

  logic [16:0]         abs_l;
  logic [16:0]         abs_r;
  logic signed [7:0]   span;
  logic signed [7:0]   integral_upd;
  logic signed [17:0]  regulator_upd;

  // move type three runs as forward
  assign mt = (state.cur_move_type == tsp_pkg::MOVE_FWD_ALT) ? tsp_pkg::MOVE_FWD
                                                              : state.cur_move_type;

  // progress from the encoder pair, floor-halved and saturated
  assign lc = {item.left_pulses[15], item.left_pulses};
  assign rc = {item.right_pulses[15], item.right_pulses};

  always_comb begin
    case (mt)
      tsp_pkg::MOVE_FWD: pair = lc + rc;
      tsp_pkg::MOVE_CW:  pair = lc - rc;
      default:           pair = rc - lc;
    endcase
  end

  assign half_pair = pair >>> 1;
  assign prog_wide = {{(PW-17){half_pair[16]}}, half_pair};
  assign prog = (prog_wide > PMAX) ? PMAX : ((prog_wide < PMIN) ? PMIN : prog_wide);

  assign target_ext = {{(PW-15){1'b0}}, state.target_pulses};
  assign half_ext   = {{(PW-14){1'b0}}, state.target_pulses[14:1]};
  assign reached    = (prog >= target_ext);
  assign below_half = (prog < half_ext);

  // interval timer and hold-time count ahead of the ramp
  assign timer_dec = (state.ramp_timer != 16'd0) ? state.ramp_timer - 16'd1 : state.ramp_timer;

  always_comb begin
    dz_pre = state.dead_zone_count;
    if (state.phase == tsp_pkg::PH_HOLD) begin
      if (state.dead_zone_count < cfg.dead_zone_limit_ticks) begin
        dz_pre = state.dead_zone_count + 16'd1;
      end else begin
        dz_pre = cfg.dead_zone_limit_ticks;
      end
    end else if (state.phase == tsp_pkg::PH_MIRROR && state.dead_zone_count != 16'd0) begin
      dz_pre = state.dead_zone_count - 16'd1;
    end
  end

  // four-phase ramp, switching at half the target
  assign decel_floor = {2'b00, cfg.min_speed} + {2'b00, cfg.decel_step};

  always_comb begin
    sp = state.cur_speed;
    ph = state.phase;
    tm = timer_dec;
    dz = dz_pre;
    if (below_half) begin
      if (state.phase == tsp_pkg::PH_ACCEL) begin
        if (state.cur_speed < {1'b0, cfg.max_speed}) begin
          if (timer_dec == 16'd0) begin
            tm = cfg.ramp_interval_ticks;
            sp = state.cur_speed + {1'b0, cfg.accel_step};
          end
        end else begin
          ph = tsp_pkg::PH_HOLD;
          dz = 16'd0;
        end
      end else if (state.phase != tsp_pkg::PH_HOLD) begin
        ph = tsp_pkg::PH_ACCEL;
      end
    end else begin
      case (state.phase)
        tsp_pkg::PH_HOLD: ph = tsp_pkg::PH_MIRROR;
        tsp_pkg::PH_MIRROR: begin
          if (dz_pre == 16'd0) ph = tsp_pkg::PH_DECEL;
        end
        tsp_pkg::PH_DECEL: begin
          if (state.cur_speed > {1'b0, cfg.min_speed} && timer_dec == 16'd0) begin
            tm = cfg.ramp_interval_ticks;
            if ({1'b0, state.cur_speed} >= decel_floor) begin
              sp = state.cur_speed - {1'b0, cfg.decel_step};
            end else begin
              sp = {1'b0, cfg.min_speed};
            end
          end
        end
        default: ph = tsp_pkg::PH_DECEL;
      endcase
    end
  end

  // drive: forward uses the ramped speed, rotation the speed before the ramp
  assign drive_speed = (mt == tsp_pkg::MOVE_FWD) ? sp : state.cur_speed;
  assign drive_l = {12'd0, drive_speed} - {{2{state.regulator[17]}}, state.regulator};
  assign drive_r = {12'd0, drive_speed} + {{2{state.regulator[17]}}, state.regulator};

  // signed clamp to [0, max_speed]
  always_comb begin
    if (drive_l > $signed({13'd0, cfg.max_speed})) begin
      clamp_l = cfg.max_speed;
    end else if (drive_l < 20'sd0) begin
      clamp_l = 7'd0;
    end else begin
      clamp_l = drive_l[6:0];
    end
    if (drive_r > $signed({13'd0, cfg.max_speed})) begin
      clamp_r = cfg.max_speed;
    end else if (drive_r < 20'sd0) begin
      clamp_r = 7'd0;
    end else begin
      clamp_r = drive_r[6:0];
    end
  end

  // reversing side: left on counter-clockwise, right on clockwise
  assign power_l = (mt == tsp_pkg::MOVE_CCW) ? -$signed({1'b0, clamp_l}) : $signed({1'b0, clamp_l});
  assign power_r = (mt == tsp_pkg::MOVE_CW)  ? -$signed({1'b0, clamp_r}) : $signed({1'b0, clamp_r});

  // PI regulator on the encoder magnitudes
  assign abs_l = lc[16] ? 17'(-lc) : 17'(lc);
  assign abs_r = rc[16] ? 17'(-rc) : 17'(rc);
  assign span  = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_speed});

  always_comb begin
    integral_upd = state.integral_term;
    if ({1'b0, abs_l} > {1'b0, abs_r} + {10'd0, cfg.pulse_hysteresis}) begin
      if (state.integral_term < span) integral_upd = state.integral_term + 8'sd1;
    end else if ({1'b0, abs_r} > {1'b0, abs_l} + {10'd0, cfg.pulse_hysteresis}) begin
      if (state.integral_term > -span) integral_upd = state.integral_term - 8'sd1;
    end
  end

  assign regulator_upd = $signed({1'b0, abs_l}) - $signed({1'b0, abs_r})
                       + {{10{integral_upd[7]}}, integral_upd};

  // next state and result
  always_comb begin
    state_next = state;
    result.left_power  = 8'sd0;
    result.right_power = 8'sd0;
    result.move_done   = 1'b0;
    result.ramp_phase  = state.phase;
    if (item.req_type == tsp_pkg::REQ_START) begin
      state_next.cur_move_type   = item.move_type;
      state_next.target_pulses   = item.need_pulses;
      state_next.cur_speed       = {1'b0, cfg.min_speed};
      state_next.phase           = tsp_pkg::PH_ACCEL;
      state_next.ramp_timer      = 16'd0;
      state_next.dead_zone_count = 16'd0;
      state_next.integral_term   = 8'sd0;
      state_next.regulator       = 18'sd0;
      state_next.finished        = 1'b0;
      result.ramp_phase          = tsp_pkg::PH_ACCEL;
    end else if (state.finished) begin
      result.move_done = 1'b1;
    end else if (reached) begin
      state_next.finished  = 1'b1;
      state_next.cur_speed = 8'd0;
      result.move_done     = 1'b1;
    end else begin
      state_next.cur_speed       = sp;
      state_next.phase           = ph;
      state_next.ramp_timer      = tm;
      state_next.dead_zone_count = dz;
      if (mt != tsp_pkg::MOVE_FWD) begin
        state_next.integral_term = integral_upd;
        state_next.regulator     = regulator_upd;
      end
      result.left_power  = power_l;
      result.right_power = power_r;
      result.ramp_phase  = ph;
    end
  end

endmodule
